### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

### rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the sensor packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int MAX_PAYLOAD = 256;
	localparam int POS_CAP     = 12 + MAX_PAYLOAD;
	localparam int POS_W       = $clog2(POS_CAP + 1);
	localparam int TDATA_W     = 48;

	// configuration register indexes
	localparam logic CFG_START_CODE  = 1'b0;
	localparam logic CFG_DEVICE_ADDR = 1'b1;

	localparam logic [15:0] START_CODE_RST  = 16'hEF01;
	localparam logic [31:0] DEVICE_ADDR_RST = 32'hFFFF_FFFF;

	// frame status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TIMEOUT   = 2'd1;
	localparam logic [1:0] ST_BAD_PKT   = 2'd2;
	localparam logic [1:0] ST_WRONG_RSP = 2'd3;

	// packet type codes
	localparam logic [7:0] TYPE_CMD      = 8'h01;
	localparam logic [7:0] TYPE_DATA     = 8'h02;
	localparam logic [7:0] TYPE_ACK      = 8'h07;
	localparam logic [7:0] TYPE_END_DATA = 8'h08;

	// byte positions within a frame
	localparam logic [POS_W-1:0] POS_SC_HI   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SC_LO   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_ADDR0   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_ADDR1   = POS_W'(3);
	localparam logic [POS_W-1:0] POS_ADDR2   = POS_W'(4);
	localparam logic [POS_W-1:0] POS_ADDR3   = POS_W'(5);
	localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(6);
	localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(7);
	localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(8);
	localparam logic [POS_W-1:0] POS_CONFIRM = POS_W'(9);
	localparam logic [POS_W-1:0] POS_DATA    = POS_W'(10);
	localparam logic [POS_W-1:0] POS_MAX     = POS_W'(POS_CAP);

	localparam logic [15:0] LEN_OVERHEAD = 16'd3;
	localparam logic [15:0] LEN_MAX      = 16'(MAX_PAYLOAD + 3);

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic [1:0] status;
		logic [7:0] frame_type;
		logic [7:0] confirm_code;
		logic [8:0] payload_length;
		logic       last;
	} spd_result_t;

	function automatic logic len_ok(input logic [15:0] len);
		return (len >= LEN_OVERHEAD) && (len <= LEN_MAX);
	endfunction

endpackage

### rtl/sensor_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// sensor_packet_deframer_top
// Response packet deframer for a serial sensor module.
// ----------------------------------------------------------------------------
// Slave stream: tdata = received byte, tuser = 1 marks a receive window close
// (tdata then ignored). Master stream: one transaction per payload byte
// (tuser 0) and one status transaction per window close (tuser 1, tlast 1).
// A result appears on the master side in the cycle after the slave
// transaction that causes it. Throughput: one byte per cycle unless the
// master stalls; each byte is decoded combinationally from frame state.
// Header, unknown-type, length and checksum bytes produce no result.
// A stalled receiver holds the result register; s_tready stays high while
// the register is empty or is being drained in the same cycle.
// Reset clears the frame state, empties the result register and restores
// start code 0xEF01 and address 0xFFFFFFFF. Config writes (cfg_we) take
// effect at the next edge and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [31:0]                 cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// rx_byte
	input  logic [7:0]                  s_tdata,
	// opcode
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// data_byte, data_index, status, frame_type, confirm_code, payload_length
	output logic [spd_pkg::TDATA_W-1:0] m_tdata,
	// result_kind
	output logic                        m_tuser,
	output logic                        m_tlast
);
	import spd_pkg::*;

	spd_result_t res;
	logic        in_fire;

	assign in_fire = s_tvalid && s_tready;

	spd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.opcode    (s_tuser),
		.rx_byte   (s_tdata),
		.res       (res)
	);

	spd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.take_ok  (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### rtl/spd_parser.sv
// ----------------------------------------------------------------------------
// spd_parser
// Frame state, configuration registers and per-byte decode.
// ----------------------------------------------------------------------------
module spd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_fire,
	input  logic                opcode,
	input  logic [7:0]          rx_byte,
	output spd_pkg::spd_result_t res
);
	import spd_pkg::*;

	logic [15:0]      start_code_q;
	logic [31:0]      dev_addr_q;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             seen_q, seen_d;
	logic [1:0]       verdict_q, verdict_d;
	logic             fin_q, fin_d;
	logic [7:0]       kind_q, kind_d;
	logic [15:0]      len_q, len_d;
	logic [7:0]       conf_q, conf_d;
	logic [15:0]      sum_q, sum_d;
	logic [7:0]       rcv_hi_q, rcv_hi_d;

	logic [15:0] n16, k16, len_new, rcv_sum, sum_add;
	logic [7:0]  addr_exp;
	logic [1:0]  close_status;

	assign n16     = len_q - LEN_OVERHEAD;
	assign k16     = 16'(pos_q) - 16'(POS_DATA);
	assign len_new = {len_q[15:8], rx_byte};
	assign rcv_sum = {rcv_hi_q, rx_byte};
	assign sum_add = sum_q + 16'(rx_byte);

	always_comb begin
		case (pos_q)
			POS_ADDR0: addr_exp = dev_addr_q[31:24];
			POS_ADDR1: addr_exp = dev_addr_q[23:16];
			POS_ADDR2: addr_exp = dev_addr_q[15:8];
			default:   addr_exp = dev_addr_q[7:0];
		endcase
	end

	always_comb begin
		if (!seen_q) begin
			close_status = ST_TIMEOUT;
		end else if (pos_q < POS_DATA) begin
			close_status = ST_BAD_PKT;
		end else if (verdict_q != ST_OK) begin
			close_status = verdict_q;
		end else if (!fin_q) begin
			close_status = ST_BAD_PKT;
		end else begin
			close_status = ST_OK;
		end
	end

	always_comb begin
		pos_d     = pos_q;
		seen_d    = seen_q;
		verdict_d = verdict_q;
		fin_d     = fin_q;
		kind_d    = kind_q;
		len_d     = len_q;
		conf_d    = conf_q;
		sum_d     = sum_q;
		rcv_hi_d  = rcv_hi_q;

		res                = '0;
		res.frame_type     = kind_q;
		res.confirm_code   = conf_q;

		if (in_fire && opcode) begin
			res.valid  = 1'b1;
			res.kind   = 1'b1;
			res.status = close_status;
			res.last   = 1'b1;
			if (verdict_q == ST_OK && pos_q > POS_LEN_LO && len_ok(len_q)) begin
				res.payload_length = n16[8:0];
			end
			pos_d     = '0;
			seen_d    = 1'b0;
			verdict_d = ST_OK;
			fin_d     = 1'b0;
			kind_d    = '0;
			len_d     = '0;
			conf_d    = '0;
			sum_d     = '0;
			rcv_hi_d  = '0;
		end else if (in_fire) begin
			seen_d = 1'b1;
			if (pos_q < POS_MAX) begin
				pos_d = pos_q + POS_W'(1);
			end
			if (verdict_q == ST_OK && !fin_q) begin
				case (pos_q)
					POS_SC_HI: begin
						if (rx_byte != start_code_q[15:8]) verdict_d = ST_BAD_PKT;
					end
					POS_SC_LO: begin
						if (rx_byte != start_code_q[7:0]) verdict_d = ST_BAD_PKT;
					end
					POS_ADDR0, POS_ADDR1, POS_ADDR2, POS_ADDR3: begin
						if (rx_byte != addr_exp) verdict_d = ST_BAD_PKT;
					end
					POS_TYPE: begin
						if (rx_byte inside {TYPE_CMD, TYPE_DATA, TYPE_ACK, TYPE_END_DATA}) begin
							kind_d = rx_byte;
							sum_d  = 16'(rx_byte);
						end else begin
							verdict_d = ST_WRONG_RSP;
						end
					end
					POS_LEN_HI: begin
						len_d = {rx_byte, 8'h00};
						sum_d = sum_add;
					end
					POS_LEN_LO: begin
						len_d = len_new;
						sum_d = sum_add;
						if (len_new == '0) begin
							verdict_d = ST_WRONG_RSP;
						end else if (!len_ok(len_new)) begin
							verdict_d = ST_BAD_PKT;
						end
					end
					POS_CONFIRM: begin
						conf_d = rx_byte;
						sum_d  = sum_add;
					end
					default: begin
						if (k16 < n16) begin
							sum_d              = sum_add;
							res.valid          = 1'b1;
							res.data_byte      = rx_byte;
							res.data_index     = 8'(n16 - 16'd1 - k16);
							res.payload_length = n16[8:0];
						end else if (k16 == n16) begin
							rcv_hi_d = rx_byte;
						end else begin
							fin_d = 1'b1;
							if ((n16 != '0 && rcv_sum == '0) || rcv_sum != sum_q) begin
								verdict_d = ST_BAD_PKT;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= START_CODE_RST;
			dev_addr_q   <= DEVICE_ADDR_RST;
			pos_q        <= '0;
			seen_q       <= 1'b0;
			verdict_q    <= ST_OK;
			fin_q        <= 1'b0;
			kind_q       <= '0;
			len_q        <= '0;
			conf_q       <= '0;
			sum_q        <= '0;
			rcv_hi_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_CODE:  start_code_q <= cfg_wdata[15:0];
					CFG_DEVICE_ADDR: dev_addr_q   <= cfg_wdata;
					default:         ;
				endcase
			end
			pos_q     <= pos_d;
			seen_q    <= seen_d;
			verdict_q <= verdict_d;
			fin_q     <= fin_d;
			kind_q    <= kind_d;
			len_q     <= len_d;
			conf_q    <= conf_d;
			sum_q     <= sum_d;
			rcv_hi_q  <= rcv_hi_d;
		end
	end

endmodule

### rtl/spd_out_stage.sv
// ----------------------------------------------------------------------------
// spd_out_stage
// Result register feeding the master stream.
// ----------------------------------------------------------------------------
module spd_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spd_pkg::spd_result_t        res,
	output logic                        take_ok,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// data_byte, data_index, status, frame_type, confirm_code, payload_length
	output logic [spd_pkg::TDATA_W-1:0] m_tdata,
	// result_kind
	output logic                        m_tuser,
	output logic                        m_tlast
);
	import spd_pkg::*;

	spd_result_t res_q;
	logic        valid_q;

	assign take_ok  = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {5'b0, res_q.payload_length, res_q.confirm_code, res_q.frame_type,
		res_q.status, res_q.data_index, res_q.data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			res_q <= res;
		end
	end

endmodule

### rtl/spd_checker.sv
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks of the deframer streams, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [spd_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tuser,
	input logic                        m_tlast
);
	import spd_pkg::*;

	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	`ASSERT_CLK(a_last_is_status, clk, arst_n, m_tvalid |-> m_tlast == m_tuser)
	`ASSERT_CLK(a_status_no_data, clk, arst_n, m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h0)
	`ASSERT_NEVER(a_ready_when_empty, clk, arst_n, !m_tvalid && !s_tready)
	`ASSERT_CLK(a_close_reports, clk, arst_n, s_tvalid && s_tready && s_tuser |=> m_tvalid && m_tuser)

endmodule

bind sensor_packet_deframer_top spd_checker u_spd_checker (.*);
